// ===== hw/rtl/otbs_pkg.sv =====
// ---------------------------------------------------------------------------
// otbs_pkg: shared types and constants for the oscillator trim search
// Beat formats, command queue entries, status codes and the constants of the
// frequency computation.
// ---------------------------------------------------------------------------
package otbs_pkg;

    localparam int LOOPS        = 50;
    localparam int TRIM_MAX     = 255;

    localparam int TRIM_W       = 8;
    localparam int CAP_W        = 16;
    localparam int FREQ_W       = 32;
    localparam int ERR_W        = 24;
    localparam int PRESC_W      = 16;
    localparam int ITER_W       = 9;
    localparam int LOOP_W       = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int PERIOD_SHIFT = 12;

    localparam logic [CAP_W-1:0]  CAPTURE_TOP  = 16'hFFFF;
    localparam logic [ITER_W-1:0] ITER_CAP     = 9'd256;
    localparam logic [TRIM_W-1:0] TRIM_HIGH    = TRIM_W'(TRIM_MAX);
    localparam logic [TRIM_W-1:0] TRIM_START   = TRIM_W'(TRIM_MAX / 2);
    localparam logic [TRIM_W-1:0] TRIM_DEFAULT = TRIM_W'((TRIM_MAX + 1) / 2);

    // sum / LOOPS as sum * ceil(2^DIV_SHIFT / LOOPS) >> DIV_SHIFT, exact for 32-bit sums
    localparam int DIV_SHIFT  = FREQ_W + $clog2(LOOPS);
    localparam int DIV_MULT_W = FREQ_W + 1;
    localparam logic [63:0] DIV_MULT_FULL = ((64'd1 << DIV_SHIFT) + 64'(LOOPS) - 64'd1)
                                            / 64'(LOOPS);
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_FULL[DIV_MULT_W-1:0];
    localparam int PROD_W     = FREQ_W + DIV_MULT_W;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_CAPTURE = 1'b1;

    typedef enum logic [1:0] {
        ST_SEARCHING = 2'd0,
        ST_SUCCESS   = 2'd1,
        ST_FAILED    = 2'd2,
        ST_CAPERR    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET    = 2'd0,
        REG_MAX_ERROR = 2'd1,
        REG_PRESCALER = 2'd2,
        REG_ITER_LIM  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_CAPERR = 2'd1,
        CMD_EVAL   = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_SCALE  = 2'd1,
        BK_DECIDE = 2'd2
    } back_state_t;

    typedef struct packed {
        logic             func;
        logic [CAP_W-1:0] capture_value;
    } item_t;

    typedef struct packed {
        logic [TRIM_W-1:0] trim_value;
        status_t           status;
        logic [FREQ_W-1:0] measured_frequency;
    } result_t;

    typedef struct packed {
        logic [FREQ_W-1:0]  target_frequency;
        logic [ERR_W-1:0]   max_error;
        logic [PRESC_W-1:0] timer_prescaler;
        logic [ITER_W-1:0]  iteration_limit;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [FREQ_W-1:0] sum;
    } cmd_t;

    // decision feedback from back end to front end
    typedef struct packed {
        logic done;
        logic keep_searching;
    } fb_t;

endpackage

// ===== hw/rtl/oscillator_trim_binary_search_top.sv =====
// ---------------------------------------------------------------------------
// oscillator_trim_binary_search_top: oscillator trim calibration
// Successive-approximation search over 8-bit trim codes driven by pairs of
// timer capture values.
// ---------------------------------------------------------------------------
// Usage:
//   item channel   : one beat per start request (func 0) or capture (func 1).
//   result channel : trim to apply, status and the frequency measured at the
//                    previous trim. At most one result beat per item beat.
//   cfg channel    : register writes (target, max error, prescaler, iteration
//                    limit); always ready, write only while the block is idle.
// Result path: with the result register free, a start or capture-error result
//   is loaded from the command queue head into the result register. The capture
//   that closes a measurement (the 51st period) goes through the queue, the
//   reciprocal multiply, the prescaler multiply and the decision.
// Throughput: one item per cycle while the command queue is not full. After a
//   closing capture the item channel stalls until the back end has decided
//   whether the search continues (the decision waits while the result register
//   is held), since that decides how later captures are treated.
// Reset: search idle, trim 128, bounds 0..255, registers at their defaults.
// Receiver stall: the result register holds; the 2-entry command queue takes
//   up to two more commands, then the item channel deasserts ready.
// ---------------------------------------------------------------------------
module oscillator_trim_binary_search_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  otbs_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output otbs_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [otbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [otbs_pkg::FREQ_W-1:0]         cfg_data
);
    import otbs_pkg::*;

    cfg_t cfg_reg;
    logic push;
    cmd_t push_cmd;
    logic fifo_full;
    logic fifo_empty;
    logic cmd_pop;
    cmd_t cmd_head;
    fb_t  fb;

    // config registers, writable every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_frequency <= 32'd2097152;
            cfg_reg.max_error        <= 24'd2000;
            cfg_reg.timer_prescaler  <= '0;
            cfg_reg.iteration_limit  <= ITER_CAP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TARGET:    cfg_reg.target_frequency <= cfg_data;
                REG_MAX_ERROR: cfg_reg.max_error        <= cfg_data[ERR_W-1:0];
                REG_PRESCALER: cfg_reg.timer_prescaler  <= cfg_data[PRESC_W-1:0];
                REG_ITER_LIM:  cfg_reg.iteration_limit  <= cfg_data[ITER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // front end: pairing, accumulation, command issue
    otbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .push_cmd   (push_cmd),
        .fifo_full  (fifo_full),
        .fb         (fb)
    );

    otbs_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (cmd_pop),
        .empty    (fifo_empty),
        .head     (cmd_head)
    );

    // back end: frequency, decision, result register
    otbs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd_empty    (fifo_empty),
        .cmd_head     (cmd_head),
        .cmd_pop      (cmd_pop),
        .fb           (fb),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // a decision only arrives while the front end is holding input off
    a_fb_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        fb.done |-> !item_ready)
        else $error("decision feedback while item channel open");

    a_caperr_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_CAPERR) |-> (result.measured_frequency == '0))
        else $error("capture error result carries a frequency");

    a_failed_default: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_FAILED) |-> (result.trim_value == TRIM_DEFAULT))
        else $error("failed search without default trim");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !fifo_empty)
        else $error("command popped from empty queue");

endmodule

// ===== hw/rtl/otbs_front.sv =====
// ---------------------------------------------------------------------------
// otbs_front: capture pairing and period accumulation
// Takes input beats, pairs captures into periods, sums them and queues
// start, capture-error and evaluate commands for the back end.
// ---------------------------------------------------------------------------
module otbs_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  otbs_pkg::item_t item,
    output logic            push,
    output otbs_pkg::cmd_t  push_cmd,
    input  logic            fifo_full,
    input  otbs_pkg::fb_t   fb
);
    import otbs_pkg::*;

    logic              searching_reg, searching_next;
    logic              have_first_reg, have_first_next;
    logic [CAP_W-1:0]  first_reg, first_next;
    logic [LOOP_W-1:0] loop_reg, loop_next;
    logic [FREQ_W-1:0] sum_reg, sum_next;
    logic              wait_reg, wait_next;
    logic              fire;
    logic [CAP_W-1:0]  period;
    logic [FREQ_W-1:0] sum_add;

    // hold off input while an evaluation decides whether the search goes on, or while the command queue is full
    assign item_ready = !wait_reg && !fifo_full;
    assign fire       = item_valid && item_ready;

    assign period  = (item.capture_value > first_reg) ? (item.capture_value - first_reg)
                   : ((CAPTURE_TOP - first_reg) + item.capture_value);
    assign sum_add = (loop_reg != '0) ? (sum_reg + (FREQ_W'(period) << PERIOD_SHIFT))
                   : sum_reg;

    always_comb
    begin
        searching_next  = searching_reg;
        have_first_next = have_first_reg;
        first_next      = first_reg;
        loop_next       = loop_reg;
        sum_next        = sum_reg;
        wait_next       = wait_reg;
        push            = 1'b0;
        push_cmd.kind   = CMD_START;
        push_cmd.sum    = sum_add;
        if (fire)
        begin
            if (item.func == FUNC_START)
            begin
                searching_next  = 1'b1;
                have_first_next = 1'b0;
                loop_next       = '0;
                sum_next        = '0;
                push            = 1'b1;
                push_cmd.kind   = CMD_START;
            end
            else if (searching_reg)
            begin
                if (!have_first_reg)
                begin
                    first_next      = item.capture_value;
                    have_first_next = 1'b1;
                end
                else
                begin
                    have_first_next = 1'b0;
                    if (item.capture_value == first_reg)
                    begin
                        searching_next = 1'b0;
                        loop_next      = '0;
                        sum_next       = '0;
                        push           = 1'b1;
                        push_cmd.kind  = CMD_CAPERR;
                    end
                    else if (loop_reg < LOOP_W'(LOOPS))
                    begin
                        loop_next = loop_reg + 1'b1;
                        sum_next  = sum_add;
                    end
                    else
                    begin
                        loop_next     = '0;
                        sum_next      = '0;
                        wait_next     = 1'b1;
                        push          = 1'b1;
                        push_cmd.kind = CMD_EVAL;
                    end
                end
            end
        end
        if (fb.done)
        begin
            wait_next      = 1'b0;
            searching_next = fb.keep_searching;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            searching_reg  <= 1'b0;
            have_first_reg <= 1'b0;
            loop_reg       <= '0;
            sum_reg        <= '0;
            wait_reg       <= 1'b0;
        end
        else
        begin
            searching_reg  <= searching_next;
            have_first_reg <= have_first_next;
            loop_reg       <= loop_next;
            sum_reg        <= sum_next;
            wait_reg       <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
    end

endmodule

// ===== hw/rtl/otbs_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// otbs_cmd_fifo: command queue between front and back end
// Two-entry register queue; head is visible while not empty.
// ---------------------------------------------------------------------------
module otbs_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  otbs_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output otbs_pkg::cmd_t head
);
    import otbs_pkg::*;

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/otbs_back.sv =====
// ---------------------------------------------------------------------------
// otbs_back: frequency evaluation and search update
// Pops commands, computes the measured frequency over two multiply steps,
// moves the search bounds and drives the result register.
// ---------------------------------------------------------------------------
module otbs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  otbs_pkg::cfg_t    cfg,
    input  logic              cmd_empty,
    input  otbs_pkg::cmd_t    cmd_head,
    output logic              cmd_pop,
    output otbs_pkg::fb_t     fb,
    output logic              result_valid,
    input  logic              result_ready,
    output otbs_pkg::result_t result
);
    import otbs_pkg::*;

    back_state_t       state_reg, state_next;
    logic [TRIM_W-1:0] low_reg, low_next;
    logic [TRIM_W-1:0] high_reg, high_next;
    logic [TRIM_W-1:0] trim_reg, trim_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [PROD_W-1:0] prod_reg;
    logic [FREQ_W-1:0] freq_reg;
    result_t           result_reg, load_data;
    logic              result_valid_reg;
    logic              load;
    logic              out_free;
    logic              eval_pop;

    logic [FREQ_W-1:0]  quot;
    logic [PRESC_W:0]   presc_p1;
    logic [FREQ_W-1:0]  diff;
    logic [FREQ_W-1:0]  mag;
    logic               close;
    logic [ITER_W-1:0]  iter_inc;
    logic [ITER_W-1:0]  limit;
    logic [TRIM_W-1:0]  low_upd;
    logic [TRIM_W-1:0]  high_upd;
    logic [TRIM_W:0]    mid_sum;

    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign quot     = FREQ_W'(prod_reg >> DIV_SHIFT);
    assign presc_p1 = {1'b0, cfg.timer_prescaler} + 1'b1;

    assign diff     = freq_reg - cfg.target_frequency;
    assign mag      = diff[FREQ_W-1] ? (FREQ_W'(0) - diff) : diff;
    assign close    = (mag < FREQ_W'(cfg.max_error));
    assign iter_inc = (iter_reg < ITER_CAP) ? (iter_reg + 1'b1) : iter_reg;
    assign limit    = (cfg.iteration_limit == '0) ? ITER_W'(1)
                    : ((cfg.iteration_limit > ITER_CAP) ? ITER_CAP : cfg.iteration_limit);
    assign low_upd  = diff[FREQ_W-1] ? trim_reg : low_reg;
    assign high_upd = diff[FREQ_W-1] ? high_reg : trim_reg;
    assign mid_sum  = {1'b0, low_upd} + {1'b0, high_upd};

    always_comb
    begin
        state_next = state_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        trim_next  = trim_reg;
        iter_next  = iter_reg;
        cmd_pop    = 1'b0;
        eval_pop   = 1'b0;
        load       = 1'b0;
        load_data.trim_value         = trim_reg;
        load_data.status             = ST_SEARCHING;
        load_data.measured_frequency = '0;
        fb.done           = 1'b0;
        fb.keep_searching = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd_head.kind)
                        CMD_START:
                        begin
                            low_next  = '0;
                            high_next = TRIM_HIGH;
                            iter_next = '0;
                            trim_next = TRIM_START;
                            load      = 1'b1;
                            load_data.trim_value = TRIM_START;
                        end
                        CMD_CAPERR:
                        begin
                            load             = 1'b1;
                            load_data.status = ST_CAPERR;
                        end
                        CMD_EVAL:
                        begin
                            eval_pop   = 1'b1;
                            state_next = BK_SCALE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_SCALE:
            begin
                state_next = BK_DECIDE;
            end
            BK_DECIDE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    fb.done    = 1'b1;
                    iter_next  = iter_inc;
                    state_next = BK_IDLE;
                    load_data.measured_frequency = freq_reg;
                    if (close)
                    begin
                        load_data.status = ST_SUCCESS;
                    end
                    else
                    begin
                        low_next  = low_upd;
                        high_next = high_upd;
                        if (iter_inc >= limit)
                        begin
                            trim_next            = TRIM_DEFAULT;
                            load_data.trim_value = TRIM_DEFAULT;
                            load_data.status     = ST_FAILED;
                        end
                        else
                        begin
                            trim_next            = mid_sum[TRIM_W:1];
                            load_data.trim_value = mid_sum[TRIM_W:1];
                            fb.keep_searching    = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            low_reg          <= '0;
            high_reg         <= TRIM_HIGH;
            trim_reg         <= TRIM_DEFAULT;
            iter_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            trim_reg  <= trim_next;
            iter_reg  <= iter_next;
            if (load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // datapath: reciprocal multiply, then prescaler multiply
    always_ff @(posedge clk)
    begin
        if (eval_pop)
        begin
            prod_reg <= PROD_W'(cmd_head.sum) * PROD_W'(DIV_MULT);
        end
        if (state_reg == BK_SCALE)
        begin
            freq_reg <= FREQ_W'(presc_p1 * quot);
        end
        if (load)
        begin
            result_reg <= load_data;
        end
    end

endmodule
